>>> rtl/cfd_pkg.sv
package cfd_pkg;

   localparam int FRAME_BYTES_MAX = 64;
   localparam int OVERHEAD_BYTES  = 6;
   localparam int ADDR_W          = $clog2(FRAME_BYTES_MAX);
   localparam int COUNT_W         = 7;

   typedef logic [7:0]         byte_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_BAD_TAIL = 2'd2,
      STATUS_CHECKSUM = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAD_FIRST  = 2'd0,
      CSR_HEAD_SECOND = 2'd1,
      CSR_TAIL        = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

endpackage

>>> rtl/checksummed_frame_deframer_top.sv
// Collecting: one word per cycle when no result waits; a length error, bad tail,
//   checksum or empty-frame result appears in the cycle after the word causing it,
//   and input is held until that result is taken.
// Readout of a good frame: each payload byte passes RAM read, load and hand-off
//   states in turn, hand-off waiting out rsp_stall; input is stalled meanwhile.
// Reset: synchronous; zeroes byte count, length, state, valid; presets head/tail.
module checksummed_frame_deframer_top
   import cfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_command,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_READ    = 2'd1;
   localparam logic [1:0] ST_LOAD    = 2'd2;
   localparam logic [1:0] ST_WAIT    = 2'd3;

   logic [1:0] state_ff, state_in;
   byte_type   head_first_ff, head_second_ff, tail_ff;
   count_type  byte_count_ff, byte_count_in;
   byte_type   payload_length_ff, payload_length_in;
   byte_type   sum_ff, sum_in;
   byte_type   chk_ff, chk_in;
   byte_type   cmd_ff, cmd_in;
   addr_type   rd_ptr_ff, rd_ptr_in;
   count_type  rd_left_ff, rd_left_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   byte_type   rsp_command_ff, rsp_command_in;
   byte_type   rsp_payload_ff, rsp_payload_in;
   logic       rsp_has_byte_ff, rsp_has_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       req_accept;
   count_type  count_eff;
   count_type  new_count;
   byte_type   len_eff;
   logic [8:0] frame_len;
   logic       len_big;
   logic       ram_wr_en;
   logic       ram_rd_en;
   byte_type   ram_rd_data;

   // Hold input off during readout or while a result waits; the store is then
   // never written and read in the same stretch, so no forwarding is needed.
   assign req_stall  = (state_ff != ST_COLLECT) || rsp_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign count_eff = (byte_count_ff >= COUNT_W'(FRAME_BYTES_MAX)) ? '0 : byte_count_ff;
   assign new_count = count_eff + COUNT_W'(1);
   assign len_eff   = (new_count == COUNT_W'(4)) ? req_rx_byte : payload_length_ff;
   assign frame_len = {1'b0, len_eff} + 9'(OVERHEAD_BYTES);
   assign len_big   = ({1'b0, req_rx_byte} + 9'(OVERHEAD_BYTES)) > 9'(FRAME_BYTES_MAX);
   assign ram_rd_en = (state_ff == ST_READ);

   cfd_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_eff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in          = state_ff;
      byte_count_in     = byte_count_ff;
      payload_length_in = payload_length_ff;
      sum_in            = sum_ff;
      chk_in            = chk_ff;
      cmd_in            = cmd_ff;
      rd_ptr_in         = rd_ptr_ff;
      rd_left_in        = rd_left_ff;
      ram_wr_en         = 1'b0;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_command_in    = rsp_command_ff;
      rsp_payload_in    = rsp_payload_ff;
      rsp_has_byte_in   = rsp_has_byte_ff;
      rsp_last_in       = rsp_last_ff;

      case (state_ff)
         ST_COLLECT: begin
            if (req_accept) begin
               ram_wr_en     = 1'b1;
               byte_count_in = new_count;
               if ((new_count == COUNT_W'(1) && req_rx_byte != head_first_ff) ||
                   (new_count == COUNT_W'(2) && req_rx_byte != head_second_ff)) begin
                  // drop the word and start again
                  byte_count_in     = '0;
                  payload_length_in = '0;
               end else if (new_count == COUNT_W'(4) && len_big) begin
                  byte_count_in     = '0;
                  payload_length_in = '0;
                  rsp_valid_in      = 1'b1;
                  rsp_status_in     = STATUS_LENGTH;
                  rsp_command_in    = '0;
                  rsp_payload_in    = '0;
                  rsp_has_byte_in   = 1'b0;
                  rsp_last_in       = 1'b1;
               end else if ({2'b0, new_count} < frame_len) begin
                  payload_length_in = len_eff;
                  if (new_count == COUNT_W'(3)) begin
                     cmd_in = req_rx_byte;
                     sum_in = req_rx_byte;
                  end else if (new_count >= COUNT_W'(4) &&
                               {2'b0, new_count} < frame_len - 9'd1) begin
                     sum_in = sum_ff + req_rx_byte;
                  end else if ({2'b0, new_count} == frame_len - 9'd1) begin
                     chk_in = req_rx_byte;
                  end
               end else begin
                  // tail word: check tail first, then checksum
                  byte_count_in     = '0;
                  payload_length_in = '0;
                  rsp_command_in    = '0;
                  rsp_payload_in    = '0;
                  rsp_has_byte_in   = 1'b0;
                  rsp_last_in       = 1'b1;
                  rsp_status_in     = STATUS_GOOD;
                  if (req_rx_byte != tail_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_BAD_TAIL;
                  end else if (sum_ff != chk_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_CHECKSUM;
                  end else if (payload_length_ff == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_command_in = cmd_ff;
                  end else begin
                     rd_ptr_in  = ADDR_W'(4);
                     rd_left_in = payload_length_ff[COUNT_W-1:0];
                     state_in   = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_GOOD;
            rsp_command_in  = cmd_ff;
            rsp_payload_in  = ram_rd_data;
            rsp_has_byte_in = 1'b1;
            rsp_last_in     = (rd_left_ff == COUNT_W'(1));
            state_in        = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               rd_left_in = rd_left_ff - COUNT_W'(1);
               rd_ptr_in  = rd_ptr_ff + ADDR_W'(1);
               state_in   = rsp_last_ff ? ST_COLLECT : ST_READ;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_COLLECT;
         byte_count_ff     <= '0;
         payload_length_ff <= '0;
         rsp_valid_ff      <= 1'b0;
         head_first_ff     <= 8'd170;
         head_second_ff    <= 8'd170;
         tail_ff           <= 8'd187;
      end else begin
         state_ff          <= state_in;
         byte_count_ff     <= byte_count_in;
         payload_length_ff <= payload_length_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_HEAD_FIRST:  head_first_ff  <= csr_wdata;
               CSR_HEAD_SECOND: head_second_ff <= csr_wdata;
               CSR_TAIL:        tail_ff        <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff          <= sum_in;
      chk_ff          <= chk_in;
      cmd_ff          <= cmd_in;
      rd_ptr_ff       <= rd_ptr_in;
      rd_left_ff      <= rd_left_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_command_ff  <= rsp_command_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_has_byte_ff <= rsp_has_byte_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_command      = rsp_command_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_has_byte     = rsp_has_byte_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_presents: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> rsp_valid_ff && rsp_has_byte_ff)
      else $error("payload load did not present a word");

   a_last_matches_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> rsp_last_ff == (rd_left_ff == COUNT_W'(1)))
      else $error("last flag out of step with readout count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < COUNT_W'(FRAME_BYTES_MAX))
      else $error("byte count beyond frame store");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_GOOD |->
         !rsp_has_byte_ff && rsp_last_ff && state_ff == ST_COLLECT)
      else $error("error result not a lone final word");
`endif

endmodule

>>> rtl/cfd_ram.sv
module cfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
